/* src/atrlc_pkg.sv */
// ----------------------------------------------------------------------------
// atrlc_pkg
// Shared types and constants for the AT response line classifier.
// ----------------------------------------------------------------------------
package atrlc_pkg;

  // request opcodes
  localparam logic [1:0] OP_BYTE   = 2'd0;
  localparam logic [1:0] OP_CMD    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // result event kinds
  localparam logic [2:0] EV_EXPECTED = 3'd0;
  localparam logic [2:0] EV_ERROR    = 3'd1;
  localparam logic [2:0] EV_INTER    = 3'd2;
  localparam logic [2:0] EV_URC      = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;
  localparam logic [2:0] EV_BUSY     = 3'd5;

  // configuration register indexes
  localparam logic [1:0] REG_EXPECTED_TEXT   = 2'd0;
  localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_LIMIT   = 2'd2;
  localparam logic [1:0] REG_URC_ENABLE      = 2'd3;

  localparam logic [63:0] EXPECTED_TEXT_RST   = 64'd19279;
  localparam logic [3:0]  EXPECTED_LENGTH_RST = 4'd2;
  localparam logic [15:0] TIMEOUT_LIMIT_RST   = 16'd5000;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [7:0] CH_FIRST = 8'd32;
  localparam logic [7:0] CH_LAST  = 8'd126;

  // width of a job's line length, enough for the largest line store
  localparam int LEN_W = 8;

  // keyword table
  localparam int NUM_KW   = 7;
  localparam int KW_OK    = 0;
  localparam int KW_ERROR = 1;
  localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd2, 4'd5, 4'd7, 4'd10, 4'd4, 4'd11, 4'd4};
  localparam logic [87:0] KW_STR [NUM_KW] = '{
    88'("OK"), 88'("ERROR"), 88'("CONNECT"), 88'("NO CARRIER"),
    88'("BUSY"), 88'("NO DIALTONE"), 88'("RING")
  };

  typedef struct packed {
    logic [63:0] expected_text;
    logic [3:0]  expected_length;
    logic [15:0] timeout_limit;
    logic        urc_enable;
  } cfg_t;

  // one unit of work for the echo side; zero length means a single event
  typedef struct packed {
    logic [2:0]       kind;
    logic [LEN_W-1:0] len;
    logic             bank;
  } job_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } bank_free_t;

  // character of keyword k at position pos, zero past its end
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
    logic [7:0] ch;
    ch = 8'd0;
    if (pos < KW_LEN[k]) begin
      ch = KW_STR[k][8 * (int'(KW_LEN[k]) - 1 - int'(pos)) +: 8];
    end
    return ch;
  endfunction

endpackage

/* src/atrlc_queue.sv */
// ----------------------------------------------------------------------------
// atrlc_queue
// Two-entry job queue between the classifier front and the echo back.
// ----------------------------------------------------------------------------
module atrlc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  atrlc_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output atrlc_pkg::job_t  head
);
  import atrlc_pkg::*;

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

endmodule

/* src/atrlc_front.sv */
// ----------------------------------------------------------------------------
// atrlc_front
// Accepts requests, gathers line characters, tracks the pending command and
// its timeout, and classifies finished lines into jobs for the echo side.
// ----------------------------------------------------------------------------
module atrlc_front #(
  parameter  int LINE_CAPACITY = 64,
  localparam int LW            = $clog2(LINE_CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             op,
  input  logic [7:0]             rx_byte,
  input  atrlc_pkg::cfg_t        cfg,
  output logic                   q_push,
  output atrlc_pkg::job_t        q_job,
  input  logic                   q_full,
  input  atrlc_pkg::bank_free_t  bank_free,
  output logic                   mem_we,
  output logic [LW:0]            mem_waddr,
  output logic [6:0]             mem_wdata
);
  import atrlc_pkg::*;

  logic [LW-1:0] line_length;
  logic [15:0]   keyword_match_flags;
  logic          command_pending;
  logic [15:0]   elapsed_ticks;
  logic          cur_bank;
  logic [1:0]    bank_busy;
  logic [6:0]    head_chars [8];

  logic        accept;
  logic        is_eol;
  logic        printable;
  logic [8:0]  len_ext;
  logic [3:0]  exp_n;
  logic        exp_match;
  logic [NUM_KW-1:0] kw_full;
  logic [NUM_KW-1:0] kw_exact;
  logic        idle_urc;
  logic [2:0]  line_kind;
  logic        line_job;
  logic        eol_event;
  logic [15:0] ticks_next;
  logic        timeout_fire;
  logic        need_line;
  logic        need_single;
  logic [15:0] flags_next;

  assign accept    = in_valid && !in_stall;
  assign is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign printable = (rx_byte >= CH_FIRST) && (rx_byte <= CH_LAST);
  assign len_ext   = 9'(line_length);
  assign exp_n     = (cfg.expected_length > 4'd8) ? 4'd8 : cfg.expected_length;

  always_comb begin
    exp_match = (exp_n != 4'd0) && (len_ext == 9'(exp_n));
    for (int i = 0; i < 8; i++) begin
      if ((4'(i) < exp_n) && ({1'b0, head_chars[i]} != cfg.expected_text[8*i +: 8])) begin
        exp_match = 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      kw_full[k]  = keyword_match_flags[k] && (len_ext >= 9'(KW_LEN[k]));
      kw_exact[k] = kw_full[k] && (len_ext == 9'(KW_LEN[k]));
    end
  end

  assign idle_urc = (head_chars[0] == CH_PLUS) ||
                    (!(kw_exact[KW_OK] || kw_exact[KW_ERROR]) && !(|kw_full[NUM_KW-1:2]));

  always_comb begin
    if (command_pending) begin
      line_job = 1'b1;
      if (exp_match) begin
        line_kind = EV_EXPECTED;
      end else if (kw_exact[KW_ERROR]) begin
        line_kind = EV_ERROR;
      end else begin
        line_kind = EV_INTER;
      end
    end else begin
      line_job  = cfg.urc_enable && idle_urc;
      line_kind = EV_URC;
    end
  end

  // keyword flags drop as soon as a character disagrees
  always_comb begin
    flags_next = keyword_match_flags;
    for (int k = 0; k < NUM_KW; k++) begin
      if ((len_ext < 9'(KW_LEN[k])) && (kw_char(3'(k), len_ext[3:0]) != rx_byte)) begin
        flags_next[k] = 1'b0;
      end
    end
  end

  assign eol_event    = (op == OP_BYTE) && is_eol && (line_length != '0);
  assign ticks_next   = (elapsed_ticks == 16'hFFFF) ? elapsed_ticks : elapsed_ticks + 16'd1;
  assign timeout_fire = command_pending && (ticks_next > cfg.timeout_limit);
  assign need_line    = eol_event && line_job;
  assign need_single  = ((op == OP_CMD) && command_pending) || ((op == OP_TICK) && timeout_fire);

  // a line job needs the other buffer free, since the next line goes there
  assign in_stall = (need_line && (q_full || bank_busy[~cur_bank])) || (need_single && q_full);
  assign q_push   = accept && (need_line || need_single);

  always_comb begin
    q_job.bank = cur_bank;
    if (need_line) begin
      q_job.kind = line_kind;
      q_job.len  = LEN_W'(line_length);
    end else begin
      q_job.kind = (op == OP_CMD) ? EV_BUSY : EV_TIMEOUT;
      q_job.len  = '0;
    end
  end

  assign mem_we    = accept && (op == OP_BYTE) && !is_eol && printable &&
                     (len_ext < 9'(LINE_CAPACITY - 1));
  assign mem_waddr = {cur_bank, line_length};
  assign mem_wdata = rx_byte[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length         <= '0;
      keyword_match_flags <= 16'hFFFF;
      command_pending     <= 1'b0;
      elapsed_ticks       <= 16'd0;
      cur_bank            <= 1'b0;
      bank_busy           <= 2'b00;
    end else begin
      if (bank_free.valid) begin
        bank_busy[bank_free.bank] <= 1'b0;
      end
      if (accept) begin
        case (op)
          OP_BYTE: begin
            if (eol_event) begin
              line_length         <= '0;
              keyword_match_flags <= 16'hFFFF;
              if (command_pending && (line_kind == EV_EXPECTED || line_kind == EV_ERROR)) begin
                command_pending <= 1'b0;
              end
              if (need_line) begin
                bank_busy[cur_bank] <= 1'b1;
                cur_bank            <= ~cur_bank;
              end
            end else if (mem_we) begin
              keyword_match_flags <= flags_next;
              line_length         <= line_length + LW'(1);
            end
          end
          OP_CMD: begin
            if (!command_pending) begin
              command_pending <= 1'b1;
              elapsed_ticks   <= 16'd0;
            end
          end
          OP_CANCEL: begin
            command_pending <= 1'b0;
            elapsed_ticks   <= 16'd0;
          end
          OP_TICK: begin
            if (command_pending) begin
              elapsed_ticks <= ticks_next;
              if (timeout_fire) begin
                command_pending <= 1'b0;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // first characters kept aside for the expected reply compare
  always_ff @(posedge clk) begin
    if (mem_we && (len_ext < 9'd8)) begin
      head_chars[len_ext[2:0]] <= mem_wdata;
    end
  end

endmodule

/* src/atrlc_back.sv */
// ----------------------------------------------------------------------------
// atrlc_back
// Echo side: holds the two line buffers, takes jobs from the queue and
// plays lines out one character per result through a read and output stage.
// ----------------------------------------------------------------------------
module atrlc_back #(
  parameter  int LINE_CAPACITY = 64,
  localparam int LW            = $clog2(LINE_CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  atrlc_pkg::job_t        q_head,
  output logic                   q_pop,
  output atrlc_pkg::bank_free_t  bank_free,
  input  logic                   mem_we,
  input  logic [LW:0]            mem_waddr,
  input  logic [6:0]             mem_wdata,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             event_kind,
  output logic [6:0]             line_char,
  output logic                   last
);
  import atrlc_pkg::*;

  logic [6:0] line_mem [2**(LW+1)];

  logic          active;
  job_t          job;
  logic [LW-1:0] idx;

  logic       rd_valid;
  logic [6:0] rd_data;
  logic [2:0] rd_kind;
  logic       rd_single;
  logic       rd_last;

  logic issue;
  logic move;
  logic job_single;
  logic job_last;

  assign move       = rd_valid && (!out_valid || !out_stall);
  assign issue      = active && (!rd_valid || move);
  assign job_single = (job.len == '0);
  assign job_last   = job_single || ((LEN_W'(idx) + LEN_W'(1)) == job.len);
  assign q_pop      = !active && q_valid;

  assign bank_free.valid = issue && job_last && !job_single;
  assign bank_free.bank  = job.bank;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= line_mem[{job.bank, idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        active <= 1'b1;
      end else if (issue && job_last) begin
        active <= 1'b0;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (move) begin
        rd_valid <= 1'b0;
      end
      if (!out_valid || !out_stall) begin
        out_valid <= rd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
      idx <= '0;
    end else if (issue) begin
      idx <= idx + LW'(1);
    end
    if (issue) begin
      rd_kind   <= job.kind;
      rd_single <= job_single;
      rd_last   <= job_last;
    end
    if (move) begin
      event_kind <= rd_kind;
      line_char  <= rd_single ? 7'd0 : rd_data;
      last       <= rd_last;
    end
  end

endmodule

/* src/at_response_line_classifier.sv */
// ----------------------------------------------------------------------------
// at_response_line_classifier
// Gathers received modem lines, classifies them against the pending command
// and keyword rules, and echoes reported lines one character per result.
// ----------------------------------------------------------------------------
//
//  channel  handshake           payload
//  -------  ------------------  -----------------------------
//  in       in_valid/in_stall   op, rx_byte
//  out      out_valid/out_stall event_kind, line_char, last
//  cfg      cfg_write           cfg_index, cfg_data
//
// a request is taken while in_valid is high and in_stall low; an echoed line
// goes through the job queue, job, read and output registers and then gives one
// character per cycle while out_stall is low, set by the single read port of the line buffer memory
// a line end that reports stalls while the previous line is still echoing
// out of the other buffer, or while the two-entry job queue is full
// reset is synchronous and needs no clearing pass
//
module at_response_line_classifier #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [6:0]  line_char,
  output logic        last,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import atrlc_pkg::*;

  localparam int LW = $clog2(LINE_CAPACITY);

  cfg_t       cfg;
  logic       q_push;
  job_t       q_job;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  job_t       q_head;
  bank_free_t bank_free;
  logic       mem_we;
  logic [LW:0] mem_waddr;
  logic [6:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_text   <= EXPECTED_TEXT_RST;
      cfg.expected_length <= EXPECTED_LENGTH_RST;
      cfg.timeout_limit   <= TIMEOUT_LIMIT_RST;
      cfg.urc_enable      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_EXPECTED_TEXT:   cfg.expected_text   <= cfg_data;
        REG_EXPECTED_LENGTH: cfg.expected_length <= cfg_data[3:0];
        REG_TIMEOUT_LIMIT:   cfg.timeout_limit   <= cfg_data[15:0];
        REG_URC_ENABLE:      cfg.urc_enable      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  atrlc_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .q_push    (q_push),
    .q_job     (q_job),
    .q_full    (q_full),
    .bank_free (bank_free),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  atrlc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  atrlc_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .bank_free  (bank_free),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .line_char  (line_char),
    .last       (last)
  );

  // a job is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // a line being freed is never the one being written
  a_bank_apart: assert property (@(posedge clk) disable iff (rst)
    (bank_free.valid && mem_we) |-> (mem_waddr[LW] != bank_free.bank))
    else $error("line write into buffer still being echoed");

  // a pushed line job always carries a non-empty line
  a_line_nonempty: assert property (@(posedge clk) disable iff (rst)
    (q_push && (q_job.kind == EV_EXPECTED || q_job.kind == EV_ERROR ||
                q_job.kind == EV_INTER || q_job.kind == EV_URC)) |-> (q_job.len != '0))
    else $error("empty line queued for echo");

endmodule
